// ===== design/fbb_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbb_pkg
// shared constants, request codes, state type and control structs for the
// free block bitmap
// ---------------------------------------------------------------------------
package fbb_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int BLK_W      = $clog2(MAX_BLOCKS) + 1;
  localparam int END_W      = BLK_W + 1;

  localparam int KIND_W     = 2;
  localparam int START_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int CFG_W      = 13;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [KIND_W-1:0] KIND_FORMAT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd3;

  localparam logic [0:0] REG_DISK_BLOCKS     = 1'b0;
  localparam logic [0:0] REG_RESERVED_BLOCKS = 1'b1;

  localparam logic [CFG_W-1:0] DISK_BLOCKS_RST     = CFG_W'(MAX_BLOCKS);
  localparam logic [CFG_W-1:0] RESERVED_BLOCKS_RST = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } fbb_state_t;

  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } fbb_cmd_t;

  typedef struct packed {
    logic              empty;
    logic [ADDR_W-1:0] w_first;
    logic [ADDR_W-1:0] w_last;
  } fbb_sts_t;

endpackage : fbb_pkg
`default_nettype wire

// ===== design/free_block_bitmap_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// free_block_bitmap_core
// free-space bitmap for a block store with format, mark, free and find-free
// ---------------------------------------------------------------------------
// A request walks the map words its span touches: mark and free walk the words
// of the clipped run, format clears all words and then walks the reserved blocks,
// and find walks every word below disk_blocks, up to the full 4096-block volume.
// The map memory has one read port and one write port, each used once per cycle.
// Results wait in an output register, so the next request is taken while the
// previous result is still pending.
// Configuration registers must be written only while no request is in flight.
module free_block_bitmap_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [fbb_pkg::IN_DATA_W-1:0]    in_tdata,   // start_block, block_count
  input  wire logic [fbb_pkg::KIND_W-1:0]       in_tuser,   // kind
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [fbb_pkg::OUT_DATA_W-1:0]        out_tdata,  // free_block, found, status
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [fbb_pkg::PADDR_W-1:0]      cfg_paddr,
  input  wire logic [fbb_pkg::PDATA_W-1:0]      cfg_pwdata,
  output logic [fbb_pkg::PDATA_W-1:0]           cfg_prdata,
  output logic                                  cfg_pready
);

  logic [fbb_pkg::CFG_W-1:0] disk_blocks_r, reserved_blocks_r;
  logic                      cfg_wr;

  fbb_pkg::fbb_cmd_t cmd;
  fbb_pkg::fbb_sts_t sts;
  logic              res_load, out_busy;
  logic [fbb_pkg::START_W-1:0] free_block;
  logic              found, status;

  logic                            out_valid_r;
  logic [fbb_pkg::OUT_DATA_W-1:0]  out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_blocks_r     <= fbb_pkg::DISK_BLOCKS_RST;
      reserved_blocks_r <= fbb_pkg::RESERVED_BLOCKS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        fbb_pkg::REG_DISK_BLOCKS:     disk_blocks_r     <= cfg_pwdata[fbb_pkg::CFG_W-1:0];
        fbb_pkg::REG_RESERVED_BLOCKS: reserved_blocks_r <= cfg_pwdata[fbb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      fbb_pkg::REG_DISK_BLOCKS:     cfg_prdata = fbb_pkg::PDATA_W'(disk_blocks_r);
      fbb_pkg::REG_RESERVED_BLOCKS: cfg_prdata = fbb_pkg::PDATA_W'(reserved_blocks_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  assign out_busy = out_valid_r && !out_tready;

  fbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_busy  (out_busy),
    .res_load  (res_load),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbb_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .kind            (in_tuser),
    .start_block     (in_tdata[fbb_pkg::START_W-1:0]),
    .block_count     (in_tdata[fbb_pkg::START_W +: fbb_pkg::COUNT_W]),
    .disk_blocks     (disk_blocks_r),
    .reserved_blocks (reserved_blocks_r),
    .sts             (sts),
    .free_block      (free_block),
    .found           (found),
    .status          (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= fbb_pkg::OUT_DATA_W'({status, found, free_block});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_find_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[fbb_pkg::START_W]) |-> !out_tdata[fbb_pkg::START_W + 1])
    else $error("find result carries clip status");

endmodule : free_block_bitmap_core
`default_nettype wire

// ===== design/fbb_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbb_dpath
// bitmap word memory with per-word valid bits, run bounds and the per-word
// update and first-free search
// ---------------------------------------------------------------------------
module fbb_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fbb_pkg::fbb_cmd_t            cmd,
  input  wire logic [fbb_pkg::KIND_W-1:0]   kind,
  input  wire logic [fbb_pkg::START_W-1:0]  start_block,
  input  wire logic [fbb_pkg::COUNT_W-1:0]  block_count,
  input  wire logic [fbb_pkg::CFG_W-1:0]    disk_blocks,
  input  wire logic [fbb_pkg::CFG_W-1:0]    reserved_blocks,
  output fbb_pkg::fbb_sts_t                 sts,
  output logic [fbb_pkg::START_W-1:0]       free_block,
  output logic                              found,
  output logic                              status
);

  logic [fbb_pkg::WORD_BITS-1:0] mem [fbb_pkg::MAP_WORDS];
  logic [fbb_pkg::MAP_WORDS-1:0] valid_r;

  logic [fbb_pkg::KIND_W-1:0]    kind_r;
  logic [fbb_pkg::BLK_W-1:0]     lo_r, hi_r;
  logic                          clip_r;
  logic [fbb_pkg::BLK_W-1:0]     lo_nxt, hi_nxt;
  logic                          clip_nxt;
  logic [fbb_pkg::BLK_W-1:0]     lim;
  logic [fbb_pkg::END_W-1:0]     lo_ext, end_ext;
  logic [fbb_pkg::BLK_W-1:0]     hi_m1;

  logic                          p_valid_r;
  logic [fbb_pkg::ADDR_W-1:0]    p_addr_r;
  logic [fbb_pkg::WORD_BITS-1:0] rdata_r;
  logic                          rvld_r;

  logic [fbb_pkg::WORD_BITS-1:0] word, mask, cand, wr_data;
  logic [fbb_pkg::BIT_W-1:0]     hit_idx;
  logic                          hit, wr_en;
  logic [fbb_pkg::BLK_W-1:0]     blk;

  logic                          found_r;
  logic [fbb_pkg::START_W-1:0]   fb_r;

  // request bounds
  always_comb begin
    lim = (disk_blocks > fbb_pkg::BLK_W'(fbb_pkg::MAX_BLOCKS)) ?
          fbb_pkg::BLK_W'(fbb_pkg::MAX_BLOCKS) : disk_blocks;
    unique case (kind) inside
      fbb_pkg::KIND_FORMAT: begin
        lo_ext  = '0;
        end_ext = fbb_pkg::END_W'(reserved_blocks);
      end
      fbb_pkg::KIND_MARK, fbb_pkg::KIND_FREE: begin
        lo_ext  = fbb_pkg::END_W'(start_block);
        end_ext = fbb_pkg::END_W'(start_block) + fbb_pkg::END_W'(block_count);
      end
      default: begin
        lo_ext  = '0;
        end_ext = fbb_pkg::END_W'(lim);
      end
    endcase
    lo_nxt   = fbb_pkg::BLK_W'(lo_ext);
    hi_nxt   = (end_ext > fbb_pkg::END_W'(lim)) ? lim : fbb_pkg::BLK_W'(end_ext);
    clip_nxt = (kind != fbb_pkg::KIND_FIND) && (end_ext > lo_ext) &&
               (end_ext > fbb_pkg::END_W'(lim));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign hi_m1       = hi_r - fbb_pkg::BLK_W'(1);
  assign sts.empty   = (hi_r <= lo_r);
  assign sts.w_first = lo_r[fbb_pkg::BIT_W +: fbb_pkg::ADDR_W];
  assign sts.w_last  = hi_m1[fbb_pkg::BIT_W +: fbb_pkg::ADDR_W];

  // map memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[p_addr_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
      rvld_r  <= valid_r[cmd.rd_addr];
      p_addr_r <= cmd.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.rd_en;
      if (cmd.load && (kind == fbb_pkg::KIND_FORMAT)) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[p_addr_r] <= 1'b1;
      end
    end
  end

  // word update and search
  always_comb begin
    word = rvld_r ? rdata_r : '0;
    for (int j = 0; j < fbb_pkg::WORD_BITS; j++) begin
      blk     = fbb_pkg::BLK_W'({p_addr_r, fbb_pkg::BIT_W'(j)});
      mask[j] = (blk >= lo_r) && (blk < hi_r);
    end
    cand    = ~word & mask;
    hit     = |cand;
    hit_idx = '0;
    for (int j = fbb_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_idx = fbb_pkg::BIT_W'(j);
      end
    end
    wr_data = (kind_r == fbb_pkg::KIND_FREE) ? (word & ~mask) : (word | mask);
    wr_en   = p_valid_r && (kind_r != fbb_pkg::KIND_FIND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      fb_r    <= '0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      fb_r    <= '0;
    end else if (p_valid_r && (kind_r == fbb_pkg::KIND_FIND) && hit && !found_r) begin
      found_r <= 1'b1;
      fb_r    <= fbb_pkg::START_W'({p_addr_r, hit_idx});
    end
  end

  assign free_block = fb_r;
  assign found      = found_r;
  assign status     = clip_r;

  a_found_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && !cmd.load) |=> (found_r && $stable(fb_r)))
    else $error("found result changed before next request");

  a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (lo_r < hi_r))
    else $error("map write for an empty run");

endmodule : fbb_dpath
`default_nettype wire

// ===== design/fbb_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fbb_ctrl
// request sequencer: takes a request, walks the map words of its span and
// hands the result to the output register
// ---------------------------------------------------------------------------
module fbb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic                out_busy,
  output logic                     res_load,
  input  wire fbb_pkg::fbb_sts_t   sts,
  output fbb_pkg::fbb_cmd_t        cmd
);

  fbb_pkg::fbb_state_t state_r, state_nxt;
  logic [fbb_pkg::ADDR_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbb_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbb_pkg::S_IDLE:   if (in_tvalid) state_nxt = fbb_pkg::S_SETUP;
      fbb_pkg::S_SETUP:  state_nxt = sts.empty ? fbb_pkg::S_RESULT : fbb_pkg::S_SCAN;
      fbb_pkg::S_SCAN:   if (cnt_r == sts.w_last) state_nxt = fbb_pkg::S_DRAIN;
      fbb_pkg::S_DRAIN:  state_nxt = fbb_pkg::S_RESULT;
      fbb_pkg::S_RESULT: if (!out_busy) state_nxt = fbb_pkg::S_IDLE;
      default:           state_nxt = fbb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    res_load    = 1'b0;
    cmd.load    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = cnt_r;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      fbb_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      fbb_pkg::S_SETUP:  cnt_nxt = sts.w_first;
      fbb_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + fbb_pkg::ADDR_W'(1);
      end
      fbb_pkg::S_DRAIN:  ;
      fbb_pkg::S_RESULT: res_load = !out_busy;
      default:           ;
    endcase
  end

  a_scan_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbb_pkg::S_SCAN) |-> (cnt_r <= sts.w_last))
    else $error("word counter ran past end of span");

endmodule : fbb_ctrl
`default_nettype wire

// ===== bench/free_block_bitmap_core_tb.sv =====
// ---------------------------------------------------------------------------
// free_block_bitmap_core_tb
// Regression for the free block bitmap core. Format, mark, free and find
// requests go in on the input stream. A bit-level copy of the usage map
// predicts each result, and every result beat is checked field by field in
// arrival order. Directed runs cover the map and volume edges. Random
// traffic then runs under several volume settings, with idle and stall
// patterns on both streams and one long receiver hold-off.
// ---------------------------------------------------------------------------
module free_block_bitmap_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbb_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int LIMIT_CYCLES    = 1_500_000;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam logic [PADDR_W-1:0] ADDR_DISK_BLOCKS     = {REG_DISK_BLOCKS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_RESERVED_BLOCKS = {REG_RESERVED_BLOCKS, 2'b00};

  typedef struct packed {
    logic [START_W-1:0] free_block;
    logic               found;
    logic               status;
  } bitmap_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [KIND_W-1:0]     in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0]    cfg_paddr   = '0;
  logic [PDATA_W-1:0]    cfg_pwdata  = '0;
  logic [PDATA_W-1:0]    cfg_prdata;
  logic                  cfg_pready;

  // map copy and volume settings
  bit [MAX_BLOCKS-1:0] used_map         = '0;
  logic [CFG_W-1:0]    disk_blocks_cfg  = DISK_BLOCKS_RST;
  logic [CFG_W-1:0]    reserved_cfg     = RESERVED_BLOCKS_RST;

  bitmap_result_t expected_results[$];
  bitmap_result_t expected_beat;
  int             mismatch_count = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             hold_left      = 0;
  int             cycle_count    = 0;

  free_block_bitmap_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // start_block, block_count
    .in_tuser   (in_tuser),    // kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // free_block, found, status
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned volume_limit();
    return (disk_blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(disk_blocks_cfg);
  endfunction

  function automatic int unsigned lowest_free(output logic hit);
    int unsigned lim;
    lim = volume_limit();
    hit = 1'b0;
    for (int unsigned b = 0; b < lim; b++) begin
      if (!used_map[b]) begin
        hit = 1'b1;
        return b;
      end
    end
    return 0;
  endfunction

  function automatic logic apply_run(int unsigned first, int unsigned count, bit used);
    int unsigned lim;
    logic        clipped;
    lim = volume_limit();
    clipped = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (first + i < lim) used_map[first + i] = used;
      else clipped = 1'b1;
    end
    return clipped;
  endfunction

  function automatic bitmap_result_t predict_request(logic [KIND_W-1:0] kind,
                                                     int unsigned start, int unsigned count);
    bitmap_result_t res;
    logic           hit;
    int unsigned    blk;
    res = '0;
    case (kind)
      KIND_FORMAT: begin
        used_map = '0;
        res.status = apply_run(0, reserved_cfg, 1'b1);
      end
      KIND_MARK: res.status = apply_run(start, count, 1'b1);
      KIND_FREE: res.status = apply_run(start, count, 1'b0);
      default: begin
        blk = lowest_free(hit);
        res.found = hit;
        res.free_block = hit ? blk[START_W-1:0] : '0;
      end
    endcase
    return res;
  endfunction

  // valid stays high between back-to-back beats
  task automatic send_request(logic [KIND_W-1:0] kind, logic [START_W-1:0] start,
                              logic [COUNT_W-1:0] count);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_DATA_W - START_W - COUNT_W){1'b0}}, count, start};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_request(kind, start, count));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_DISK_BLOCKS) disk_blocks_cfg = data[CFG_W-1:0];
    else if (addr == ADDR_RESERVED_BLOCKS) reserved_cfg = data[CFG_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_volume(int unsigned disk, int unsigned reserved);
    drain_results();
    cfg_write(ADDR_DISK_BLOCKS, disk);
    cfg_write(ADDR_RESERVED_BLOCKS, reserved);
  endtask

  task automatic send_random_request();
    logic [KIND_W-1:0] kind;
    int unsigned       lim, start, count, roll, first_free;
    logic              hit;
    lim = volume_limit();
    roll = $urandom_range(99);
    if (roll < 10) kind = KIND_FORMAT;
    else if (roll < 45) kind = KIND_MARK;
    else if (roll < 65) kind = KIND_FREE;
    else kind = KIND_FIND;
    roll = $urandom_range(99);
    if (roll < 60) count = $urandom_range(0, 16);
    else if (roll < 88) count = $urandom_range(0, 128);
    else if (roll < 97) count = $urandom_range(0, 1024);
    else count = $urandom_range(0, MAX_BLOCKS);
    // allocation-style marks grow the used region from the bottom
    first_free = lowest_free(hit);
    roll = $urandom_range(99);
    if (kind == KIND_MARK && hit && roll < 60) start = first_free;
    else if (roll < 80) start = $urandom_range(0, (lim + 8 > MAX_BLOCKS - 1) ?
                                                   MAX_BLOCKS - 1 : lim + 8);
    else start = $urandom_range(0, MAX_BLOCKS - 1);
    send_request(kind, start[START_W-1:0], count[COUNT_W-1:0]);
  endtask

  task automatic test_directed_runs();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(KIND_FIND,   12'hfff, 13'd4096);
    send_request(KIND_MARK,   12'd0,   13'd0);
    send_request(KIND_MARK,   12'd0,   13'd4096);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_FREE,   12'd4095, 13'd1);
    send_request(KIND_FIND,   12'h555, 13'h0aaa);
    send_request(KIND_MARK,   12'd4000, 13'd200);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_FREE,   12'h555, 13'h0aaa);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_MARK,   12'haaa, 13'd4096);
    send_request(KIND_FREE,   12'haaa, 13'h0555);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_FORMAT, 12'h123, 13'd77);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_MARK,   12'd1,   13'd31);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_MARK,   12'd0,   13'd1);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_FREE,   12'd31,  13'd2);
    send_request(KIND_FIND,   12'd0,   13'd0);
    send_request(KIND_FREE,   12'd0,   13'd4096);
  endtask

  task automatic test_volume_edges();
    // zero-size volume
    set_volume(0, 0);
    send_request(KIND_FIND,   12'd0,  13'd0);
    send_request(KIND_MARK,   12'd0,  13'd1);
    send_request(KIND_FREE,   12'd10, 13'd0);
    send_request(KIND_FORMAT, 12'd0,  13'd0);
    set_volume(0, 5);
    send_request(KIND_FORMAT, 12'd0,  13'd0);
    // volume larger than the map, reserve past it
    set_volume(8191, 8191);
    send_request(KIND_FORMAT, 12'd0,    13'd0);
    send_request(KIND_FIND,   12'd0,    13'd0);
    send_request(KIND_FREE,   12'd4095, 13'd1);
    send_request(KIND_FIND,   12'd0,    13'd0);
    set_volume(1, 1);
    send_request(KIND_FORMAT, 12'd0, 13'd0);
    send_request(KIND_FIND,   12'd0, 13'd0);
    send_request(KIND_FREE,   12'd0, 13'd2);
    send_request(KIND_FIND,   12'd0, 13'd0);
    set_volume(33, 32);
    send_request(KIND_FORMAT, 12'd0,  13'd0);
    send_request(KIND_FIND,   12'd0,  13'd0);
    send_request(KIND_MARK,   12'd30, 13'd10);
    send_request(KIND_FIND,   12'd0,  13'd0);
    send_request(KIND_FREE,   12'd32, 13'd1);
    send_request(KIND_FIND,   12'd0,  13'd0);
    set_volume(4096, 4096);
    send_request(KIND_FORMAT, 12'd0, 13'd0);
    send_request(KIND_FIND,   12'd0, 13'd0);
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct, int unsigned disk,
                                  int unsigned reserved, int count);
    set_volume(disk, reserved);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    send_request(KIND_FORMAT, START_W'($urandom_range(0, 4095)),
                 COUNT_W'($urandom_range(0, 4096)));
    repeat (count) send_random_request();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0,  0,  4096, $urandom_range(0, 64), 300);
    run_random_phase(61, 0,  $urandom_range(1, 600), $urandom_range(0, 640), 250);
    run_random_phase(0,  61, $urandom_range(600, 4096), $urandom_range(0, 200), 250);
    run_random_phase(15, 15, $urandom_range(4097, 8191), $urandom_range(0, 8191), 250);
  endtask

  // receiver holds off while the sender keeps pushing beats
  task automatic test_backpressure();
    set_volume(256, 16);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_OFF_CYCLES;
    repeat (40) send_random_request();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        expected_beat = expected_results.pop_front();
        if (out_tdata[START_W-1:0] !== expected_beat.free_block) begin
          $display("%0t: free_block expected %0d actual %0d", $time,
                   expected_beat.free_block, out_tdata[START_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[START_W] !== expected_beat.found) begin
          $display("%0t: found expected %0b actual %0b", $time,
                   expected_beat.found, out_tdata[START_W]);
          mismatch_count++;
        end
        if (out_tdata[START_W+1] !== expected_beat.status) begin
          $display("%0t: status expected %0b actual %0b", $time,
                   expected_beat.status, out_tdata[START_W+1]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("free_block_bitmap_core regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_runs();
    test_volume_edges();
    test_random_traffic();
    test_backpressure();
    drain_results();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) $display("free_block_bitmap_core regression: pass");
    else $display("free_block_bitmap_core regression: fail");
    $finish;
  end

endmodule
